// File: src/assert_macros.svh
// Assertion helper for the bank writer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held
`define SPBW_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("spbw assertion failed");

`endif

// File: src/spbw_pkg.sv
package spbw_pkg;

  // Field widths
  localparam int unsigned PIX_W  = 16;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned FLEN_W = 16;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned IDX_W  = 2;

  // Copy counts and rotate phases per mode
  localparam logic [CNT_W-1:0] COPIES_2PX = 3'd7;
  localparam logic [CNT_W-1:0] COPIES_4PX = 3'd3;
  localparam logic [3:0]       PHASE_2PX  = 4'd2;
  localparam logic [3:0]       PHASE_4PX  = 4'd4;
  localparam logic [ADDR_W-1:0] WORD_BYTES = 32'd2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_SHIFT_MODE   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_FRAME_LENGTH = 2'd1;
  localparam logic [IDX_W-1:0] CFG_DEST_BASE    = 2'd2;

  // Address steps derived from the configuration
  typedef struct packed {
    logic [ADDR_W-1:0] copy_stride;
    logic [ADDR_W-1:0] row_adj;
  } spbw_steps_t;

  // Rotate a bitmap word right
  function automatic logic [PIX_W-1:0] ror16(input logic [PIX_W-1:0] v,
                                             input logic [3:0] n);
    logic [2*PIX_W-1:0] dbl;
    dbl = {v, v} >> n;
    return dbl[PIX_W-1:0];
  endfunction

endpackage

// File: src/spbw_if.sv
// Input item channel
interface spbw_in_if;
  import spbw_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_word;
  logic             first_row;

  modport source (output valid, output pixel_word, output first_row, input ready);
  modport sink (input valid, input pixel_word, input first_row, output ready);
endinterface

// Result item channel
interface spbw_out_if;
  import spbw_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] write_address;
  logic [PIX_W-1:0]  write_data;
  logic              row_done;
  logic [ADDR_W-1:0] next_cursor;

  modport source (output valid, output write_address, output write_data,
                  output row_done, output next_cursor, input ready);
  modport sink (input valid, input write_address, input write_data,
                input row_done, input next_cursor, output ready);
endinterface

// File: src/spbw_step_calc.sv
module spbw_step_calc (
  input  logic                        shift_mode,
  input  logic [spbw_pkg::FLEN_W-1:0] frame_length,
  output spbw_pkg::spbw_steps_t       steps
);
  import spbw_pkg::*;

  logic [FLEN_W+2:0]  flen_x8;
  logic [FLEN_W-1:0]  span_len;
  logic [FLEN_W-1:0]  back_lo;
  logic [ADDR_W-1:0]  back;

  // Slot step: frame length times span, low half sign-extended
  assign span_len = shift_mode ? {frame_length[FLEN_W-2:0], 1'b0} : frame_length;
  assign steps.copy_stride = {{(ADDR_W-FLEN_W){span_len[FLEN_W-1]}}, span_len};

  // Back step: 8 frames, span frames removed from the low half only
  assign flen_x8 = {frame_length, 3'b000};
  assign back_lo = flen_x8[FLEN_W-1:0] - span_len;
  assign back    = {{(ADDR_W-FLEN_W-3){1'b0}}, flen_x8[FLEN_W+2:FLEN_W], back_lo};

  // Cursor move at end of row: one word on, then back
  assign steps.row_adj = WORD_BYTES - back;

endmodule

// File: src/sprite_preshift_bank_writer.sv
// An accepted item is loaded into the copy generator, whose writes go out through the
//   output register: 7 writes per item in 2-pixel mode, 3 in 4-pixel mode, one write
//   per cycle unless the output stalls; the next item is taken with the last write.
// Reset (synchronous, rst_n low): configuration, copy count and write cursor clear to
//   zero, no item in flight, no result valid.
module sprite_preshift_bank_writer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [spbw_pkg::IDX_W-1:0] cfg_index,
  input  logic [spbw_pkg::ADDR_W-1:0] cfg_wdata,
  spbw_in_if.sink                    in_ch,
  spbw_out_if.source                 out_ch
);
  import spbw_pkg::*;
  `include "assert_macros.svh"

  // Configuration registers
  logic              shift_mode_r;
  logic [FLEN_W-1:0] frame_length_r;
  logic [ADDR_W-1:0] dest_base_r;

  // Copy generator
  logic              busy_r;
  logic [CNT_W-1:0]  left_r;
  logic [ADDR_W-1:0] cur_r;
  logic [PIX_W-1:0]  pix_r;

  // Output register
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [PIX_W-1:0]  out_data_r;
  logic              out_done_r;
  logic [ADDR_W-1:0] out_next_r;

  spbw_steps_t       steps;
  logic              emit;
  logic              last;
  logic              in_acc;
  logic [ADDR_W-1:0] addr_nxt;
  logic [PIX_W-1:0]  data_nxt;
  logic [ADDR_W-1:0] final_cur;
  logic [ADDR_W-1:0] cur_nxt;
  logic [CNT_W-1:0]  copies;
  logic [3:0]        phase;

  spbw_step_calc u_step_calc (
    .shift_mode   (shift_mode_r),
    .frame_length (frame_length_r),
    .steps        (steps)
  );

  assign copies = shift_mode_r ? COPIES_4PX : COPIES_2PX;
  assign phase  = shift_mode_r ? PHASE_4PX : PHASE_2PX;

  // One copy per cycle when the output register is free
  assign emit      = busy_r && (!out_valid_r || out_ch.ready);
  assign last      = (left_r == CNT_W'(1));
  assign addr_nxt  = cur_r + steps.copy_stride;
  assign data_nxt  = ror16(pix_r, phase);
  assign final_cur = addr_nxt + steps.row_adj;

  // New item enters when idle or alongside its predecessor's last write
  assign in_ch.ready = !busy_r || (emit && last);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    cur_nxt = cur_r;
    if (emit) begin
      cur_nxt = last ? final_cur : addr_nxt;
    end
    if (in_acc && in_ch.first_row) begin
      cur_nxt = dest_base_r;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_mode_r   <= 1'b0;
      frame_length_r <= '0;
      dest_base_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHIFT_MODE:   shift_mode_r   <= cfg_wdata[0];
        CFG_FRAME_LENGTH: frame_length_r <= cfg_wdata[FLEN_W-1:0];
        CFG_DEST_BASE:    dest_base_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Generator control and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      left_r <= '0;
      cur_r  <= '0;
    end else begin
      cur_r <= cur_nxt;
      if (in_acc) begin
        busy_r <= 1'b1;
        left_r <= copies;
      end else if (emit) begin
        left_r <= left_r - CNT_W'(1);
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Running rotated word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r <= in_ch.pixel_word;
    end else if (emit) begin
      pix_r <= data_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_addr_r <= addr_nxt;
      out_data_r <= data_nxt;
      out_done_r <= last;
      out_next_r <= last ? final_cur : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.write_address = out_addr_r;
  assign out_ch.write_data    = out_data_r;
  assign out_ch.row_done      = out_done_r;
  assign out_ch.next_cursor   = out_next_r;

  // Checks
  `SPBW_ASSERT(a_idle_no_copies, !busy_r |-> (left_r == '0))
  `SPBW_ASSERT(a_accept_loads_count, in_acc |=> (busy_r && (left_r == COPIES_2PX || left_r == COPIES_4PX)))
  `SPBW_ASSERT(a_next_cursor_zero, (out_valid_r && !out_done_r) |-> (out_next_r == '0))

endmodule

// File: bench/testbench.sv
module testbench;
  import spbw_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DIR_ROWS     = 18;
  localparam int RANDOM_ITEMS = 102;

  // One expected bank write
  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [PIX_W-1:0]  write_data;
    logic              row_done;
    logic [ADDR_W-1:0] next_cursor;
  } bank_write_t;

  // Directed stimulus row: optional reprogram, one sprite word, optional typed last write
  typedef struct packed {
    logic              set_cfg;
    logic              mode;
    logic [FLEN_W-1:0] flen;
    logic [ADDR_W-1:0] base;
    logic [PIX_W-1:0]  pixel;
    logic              fr;
    logic              typed;
    logic [ADDR_W-1:0] t_addr;
    logic [PIX_W-1:0]  t_data;
    logic [ADDR_W-1:0] t_next;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0] cfg_wdata;

  spbw_in_if  in_ch ();
  spbw_out_if out_ch ();

  sprite_preshift_bank_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor copy of the configuration and cursor
  logic              cur_mode;
  logic [FLEN_W-1:0] cur_flen;
  logic [ADDR_W-1:0] cur_base;
  logic [ADDR_W-1:0] model_cursor;

  bank_write_t pending_writes[$];
  dir_row_t    dir_rows[DIR_ROWS];

  int  errors = 0;
  int  words_sent = 0;
  int  writes_checked = 0;
  int  cfg_phases = 0;
  int  cycle_count = 0;
  bit  src_calm = 1'b0;
  bit  snk_calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Expected writes for one sprite word; advances the cursor copy
  function automatic void preshift_row(input logic [PIX_W-1:0] pw, input logic fr);
    int unsigned       copies;
    int unsigned       span;
    logic [3:0]        ph;
    logic [FLEN_W-1:0] prod16;
    logic [15:0]       lo;
    logic [ADDR_W-1:0] step;
    logic [ADDR_W-1:0] back;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
    bank_write_t       w;
    copies = cur_mode ? COPIES_4PX : COPIES_2PX;
    ph     = cur_mode ? PHASE_4PX : PHASE_2PX;
    span   = cur_mode ? 2 : 1;
    prod16 = FLEN_W'(cur_flen * span);
    step   = {{16{prod16[15]}}, prod16};
    // back step: flen*8, then low half only loses flen per span
    back = {13'd0, cur_flen, 3'd0};
    lo   = back[15:0];
    repeat (span) lo = lo - cur_flen;
    back[15:0] = lo;
    if (fr) model_cursor = cur_base;
    addr = model_cursor;
    pix  = pw;
    for (int unsigned k = 0; k < copies; k++) begin
      addr = addr + step;
      pix  = (pix >> ph) | (pix << (16 - ph));
      w.write_address = addr;
      w.write_data    = pix;
      w.row_done      = (k == copies - 1);
      w.next_cursor   = '0;
      if (k == copies - 1) begin
        w.next_cursor = addr + WORD_BYTES - back;
        model_cursor  = w.next_cursor;
      end
      pending_writes.push_back(w);
    end
  endfunction

  function automatic dir_row_t mk_row(input logic set_cfg, input logic mode,
                                      input logic [FLEN_W-1:0] flen,
                                      input logic [ADDR_W-1:0] base,
                                      input logic [PIX_W-1:0] pixel, input logic fr,
                                      input logic typed, input logic [ADDR_W-1:0] t_addr,
                                      input logic [PIX_W-1:0] t_data,
                                      input logic [ADDR_W-1:0] t_next);
    dir_row_t r;
    r.set_cfg = set_cfg;
    r.mode    = mode;
    r.flen    = flen;
    r.base    = base;
    r.pixel   = pixel;
    r.fr      = fr;
    r.typed   = typed;
    r.t_addr  = t_addr;
    r.t_data  = t_data;
    r.t_next  = t_next;
    return r;
  endfunction

  // Reprogram all registers once the bank writer has drained
  task automatic program_bank(input logic m, input logic [FLEN_W-1:0] fl,
                              input logic [ADDR_W-1:0] base, input bit junk);
    logic [31:0] hi;
    in_ch.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    hi = junk ? $urandom : 32'd0;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SHIFT_MODE;
    cfg_wdata <= {hi[31:1], m};
    @(posedge clk);
    cfg_index <= CFG_FRAME_LENGTH;
    cfg_wdata <= {hi[31:16], fl};
    @(posedge clk);
    cfg_index <= CFG_DEST_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode = m;
    cur_flen = fl;
    cur_base = base;
    cfg_phases++;
  endtask

  // Send one sprite word and record its expected writes at acceptance
  task automatic push_item(input logic [PIX_W-1:0] pw, input logic fr, input logic typed,
                           input logic [ADDR_W-1:0] t_addr, input logic [PIX_W-1:0] t_data,
                           input logic [ADDR_W-1:0] t_next);
    int          gap;
    bank_write_t w;
    gap = src_calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.pixel_word <= pw;
    in_ch.first_row  <= fr;
    do @(posedge clk); while (!in_ch.ready);
    preshift_row(pw, fr);
    // typed rows replace the predicted last write with the hand-derived one
    if (typed) begin
      w = pending_writes.pop_back();
      w.write_address = t_addr;
      w.write_data    = t_data;
      w.next_cursor   = t_next;
      pending_writes.push_back(w);
    end
    words_sent++;
  endtask

  // Result side: random stalls per write
  initial begin
    int gap;
    forever begin
      gap = snk_calm ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_ch.valid));
    end
  end

  // Compare each accepted write with the oldest expectation
  always @(posedge clk) begin : write_check
    bank_write_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected write: addr %h data %h", out_ch.write_address, out_ch.write_data);
        errors++;
      end else begin
        exp_w = pending_writes.pop_front();
        writes_checked++;
        if (out_ch.write_address !== exp_w.write_address) begin
          $error("write_address: expected %h, got %h", exp_w.write_address,
                 out_ch.write_address);
          errors++;
        end
        if (out_ch.write_data !== exp_w.write_data) begin
          $error("write_data: expected %h, got %h", exp_w.write_data, out_ch.write_data);
          errors++;
        end
        if (out_ch.row_done !== exp_w.row_done) begin
          $error("row_done: expected %b, got %b", exp_w.row_done, out_ch.row_done);
          errors++;
        end
        if (out_ch.next_cursor !== exp_w.next_cursor) begin
          $error("next_cursor: expected %h, got %h", exp_w.next_cursor, out_ch.next_cursor);
          errors++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    int              n;
    int              rand_sent;
    logic            m;
    logic [FLEN_W-1:0] fl;
    logic [ADDR_W-1:0] base;
    logic [PIX_W-1:0]  pw;
    logic            fr;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_SHIFT_MODE;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.pixel_word <= '0;
    in_ch.first_row  <= 1'b0;
    cur_mode     = 1'b0;
    cur_flen     = '0;
    cur_base     = '0;
    model_cursor = '0;

    // reset defaults, then extremes of both modes
    dir_rows[0]  = mk_row(0, 0, 16'h0000, 32'h0, 16'hFFFF, 0, 1, 32'h0, 16'hFFFF, 32'h2);
    dir_rows[1]  = mk_row(0, 0, 16'h0000, 32'h0, 16'h0000, 0, 1, 32'h2, 16'h0000, 32'h4);
    dir_rows[2]  = mk_row(0, 0, 16'h0000, 32'h0, 16'h0001, 1, 1, 32'h0, 16'h0004, 32'h2);
    dir_rows[3]  = mk_row(1, 1, 16'hFFFF, 32'hFFFF_FFFF, 16'h8001, 1, 1,
                          32'hFFFF_FFF9, 16'h0018, 32'hFFF8_0001);
    dir_rows[4]  = mk_row(0, 0, 16'h0, 32'h0, 16'h1234, 0, 0, 32'h0, 16'h0, 32'h0);
    dir_rows[5]  = mk_row(0, 0, 16'h0, 32'h0, 16'hFFFF, 0, 0, 32'h0, 16'h0, 32'h0);
    dir_rows[6]  = mk_row(1, 0, 16'h8000, 32'h0000_1000, 16'hA5A5, 1, 0, 32'h0, 16'h0, 32'h0);
    dir_rows[7]  = mk_row(0, 0, 16'h0, 32'h0, 16'h5A5A, 0, 0, 32'h0, 16'h0, 32'h0);
    dir_rows[8]  = mk_row(0, 0, 16'h0, 32'h0, 16'h0000, 0, 0, 32'h0, 16'h0, 32'h0);
    dir_rows[9]  = mk_row(1, 1, 16'h7FFF, 32'h8000_0000, 16'h8000, 1, 0, 32'h0, 16'h0, 32'h0);
    dir_rows[10] = mk_row(0, 0, 16'h0, 32'h0, 16'h0001, 0, 0, 32'h0, 16'h0, 32'h0);
    dir_rows[11] = mk_row(0, 0, 16'h0, 32'h0, 16'hFFFE, 1, 0, 32'h0, 16'h0, 32'h0);
    dir_rows[12] = mk_row(1, 0, 16'h0001, 32'h7FFF_FFFE, 16'hC3C3, 1, 0, 32'h0, 16'h0, 32'h0);
    dir_rows[13] = mk_row(0, 0, 16'h0, 32'h0, 16'h3C3C, 0, 0, 32'h0, 16'h0, 32'h0);
    dir_rows[14] = mk_row(1, 0, 16'hFFFF, 32'h0, 16'hFFFF, 1, 0, 32'h0, 16'h0, 32'h0);
    dir_rows[15] = mk_row(0, 0, 16'h0, 32'h0, 16'h0000, 0, 0, 32'h0, 16'h0, 32'h0);
    // zero frame length in 4-pixel mode: all copies on one address
    dir_rows[16] = mk_row(1, 1, 16'h0000, 32'hFFFF_FFFF, 16'h1234, 1, 1,
                          32'hFFFF_FFFF, 16'h2341, 32'h0000_0001);
    dir_rows[17] = mk_row(0, 0, 16'h0, 32'h0, 16'h4321, 0, 0, 32'h0, 16'h0, 32'h0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].set_cfg)
        program_bank(dir_rows[r].mode, dir_rows[r].flen, dir_rows[r].base, 1'b0);
      push_item(dir_rows[r].pixel, dir_rows[r].fr, dir_rows[r].typed,
                dir_rows[r].t_addr, dir_rows[r].t_data, dir_rows[r].t_next);
    end

    // Random phases: mostly rows opened by first_row, some without
    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      m = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
        0:       fl = 16'h0000;
        1:       fl = 16'hFFFF;
        2:       fl = 16'h8000;
        3:       fl = 16'h7FFF;
        4:       fl = 16'h0001;
        default: fl = FLEN_W'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       base = 32'h0;
        1:       base = 32'hFFFF_FFFF;
        default: base = $urandom;
      endcase
      program_bank(m, fl, base, 1'b1);
      src_calm = ($urandom_range(0, 3) == 0);
      snk_calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(6, 16);
      if (n > RANDOM_ITEMS - rand_sent) n = RANDOM_ITEMS - rand_sent;
      for (int i = 0; i < n; i++) begin
        if (i == 0) fr = ($urandom_range(0, 7) != 0);
        else        fr = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 9))
          0:       pw = 16'h0000;
          1:       pw = 16'hFFFF;
          default: pw = PIX_W'($urandom);
        endcase
        push_item(pw, fr, 1'b0, '0, '0, '0);
        rand_sent++;
      end
    end
    in_ch.valid <= 1'b0;

    // Drain, then watch for stray writes
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d sprite words over %0d register settings, both shift modes.",
             words_sent, cfg_phases);
    $display("Checked %0d bank writes against the preshift predictor.", writes_checked);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/spbw_pkg.sv
src/spbw_if.sv
src/spbw_step_calc.sv
src/sprite_preshift_bank_writer.sv
bench/testbench.sv
